// ===== hw/rtl/dfq_pkg.sv =====
// ============================================================================
// dfq_pkg
// Shared types and constants of the decimated frame queue framer: request
// and response beats, controller states and the controller/datapath link.
// ============================================================================
package dfq_pkg;

   localparam logic [1:0] ACT_PUSH  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_DONE  = 2'd2;
   localparam logic [1:0] ACT_ERROR = 2'd3;

   localparam logic [0:0] CSR_FRAME_WORDS = 1'b0;
   localparam logic [0:0] CSR_DECIMATION  = 1'b1;

   localparam logic [31:0] TAIL_WORD = 32'h7F80_0000;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  word_count;
      logic [31:0] sample_zero;
      logic [31:0] sample_one;
      logic [31:0] sample_two;
      logic [31:0] sample_three;
      logic [31:0] sample_four;
      logic [31:0] sample_five;
      logic [31:0] sample_six;
      logic [31:0] sample_seven;
      logic        link_accepts;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic        word_valid;
      logic [31:0] frame_word;
      logic        last;
      logic [2:0]  queued;
      logic [31:0] dropped_count;
      logic [31:0] error_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_WRITE,
      ST_READ,
      ST_TAIL
   } state_type;

   typedef struct packed {
      logic load_req;
      logic eval;
      logic write_word;
      logic commit_push;
      logic read_word;
      logic send_tail;
   } cmd_type;

   typedef struct packed {
      logic push_store;
      logic start_go;
      logic idx_last;
   } sts_type;

endpackage

// ===== hw/rtl/decimated_frame_queue_framer_top.sv =====
// ============================================================================
// decimated_frame_queue_framer_top
// Telemetry framer with a decimating ring queue of channel-word frames and a
// word-by-word transmit stream closed by a tail word.
//
//   channel   ports                               direction  handshake
//   request   start, busy, req_data               in         start & !busy
//   response  rsp_valid, rsp_data                 out        strobe, one cycle
//   config    csr_write_en, csr_index, csr_wdata  in         write enable
//
// A request that gives a single response beat passes through the idle and evaluation states.
// A stored push writes its N words per frame one by one: one write port on the store.
// A transmit start streams N words and then the tail word: one read port, one beat a cycle.
// Synchronous reset clears pointers, counters and state; the store is not cleared.
// Response beats cannot be stalled; the next request may start during a beat.
// ============================================================================
module decimated_frame_queue_framer_top #(
   parameter int QUEUE_SLOTS  = 8,
   parameter int MAX_CHANNELS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dfq_pkg::req_type  req_data,
   output logic              rsp_valid,
   output dfq_pkg::rsp_type  rsp_data,
   input  logic              csr_write_en,
   input  logic [0:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   dfq_pkg::cmd_type cmd;
   dfq_pkg::sts_type sts;

   dfq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   dfq_datapath #(
      .QUEUE_SLOTS  (QUEUE_SLOTS),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== hw/rtl/dfq_ctrl.sv =====
// ============================================================================
// dfq_ctrl
// Controller of the frame queue framer: sequences evaluation, word writes
// into the ring and the transmit word stream.
// ============================================================================
module dfq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dfq_pkg::sts_type  sts,
   output dfq_pkg::cmd_type  cmd
);

   dfq_pkg::state_type state_ff;
   dfq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dfq_pkg::ST_IDLE: begin
            if (start) state_in = dfq_pkg::ST_EVAL;
         end
         dfq_pkg::ST_EVAL: begin
            if (sts.push_store) state_in = dfq_pkg::ST_WRITE;
            else if (sts.start_go) state_in = dfq_pkg::ST_READ;
            else state_in = dfq_pkg::ST_IDLE;
         end
         dfq_pkg::ST_WRITE: begin
            if (sts.idx_last) state_in = dfq_pkg::ST_IDLE;
         end
         dfq_pkg::ST_READ: begin
            if (sts.idx_last) state_in = dfq_pkg::ST_TAIL;
         end
         dfq_pkg::ST_TAIL: begin
            state_in = dfq_pkg::ST_IDLE;
         end
         default: begin
            state_in = dfq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy = 1'b1;
      cmd  = '0;
      case (state_ff)
         dfq_pkg::ST_IDLE: begin
            busy         = 1'b0;
            cmd.load_req = start;
         end
         dfq_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         dfq_pkg::ST_WRITE: begin
            cmd.write_word  = 1'b1;
            cmd.commit_push = sts.idx_last;
         end
         dfq_pkg::ST_READ: begin
            cmd.read_word = 1'b1;
         end
         dfq_pkg::ST_TAIL: begin
            cmd.send_tail = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== hw/rtl/dfq_datapath.sv =====
// ============================================================================
// dfq_datapath
// Datapath of the frame queue framer: request hold register, ring store,
// pointers, decimation and event counters, configuration and response beat.
// ============================================================================
module dfq_datapath #(
   parameter int QUEUE_SLOTS  = 8,
   parameter int MAX_CHANNELS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  dfq_pkg::cmd_type  cmd,
   output dfq_pkg::sts_type  sts,
   input  dfq_pkg::req_type  req_data,
   input  logic              csr_write_en,
   input  logic [0:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   output logic              rsp_valid,
   output dfq_pkg::rsp_type  rsp_data
);

   localparam int PTR_W  = $clog2(QUEUE_SLOTS);
   localparam int DEPTH  = QUEUE_SLOTS * MAX_CHANNELS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int QW     = (PTR_W + 1 > 3) ? PTR_W + 1 : 3;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_SLOTS - 1)) r = '0;
      else r = p + PTR_W'(1);
      return r;
   endfunction

   dfq_pkg::req_type req_ff;

   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic             sending_ff, sending_in;
   logic [15:0]      skip_ff, skip_in;
   logic [31:0]      drop_ff, drop_in;
   logic [31:0]      err_ff, err_in;
   logic [3:0]       cc_ff, cc_in;
   logic [15:0]      dec_ff, dec_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ok_ff, rsp_ok_in;
   logic rsp_wv_ff, rsp_wv_in;
   logic rsp_mem_ff, rsp_mem_in;
   logic rsp_last_ff, rsp_last_in;

   logic [31:0] frame_store [DEPTH];
   logic [31:0] mem_q_ff;

   logic [PTR_W-1:0] wp_next;
   logic [PTR_W-1:0] rp_next;
   logic             full;
   logic             empty;
   logic             count_match;
   logic [15:0]      skip_inc;
   logic             keep;
   logic [7:0][31:0] samples;
   logic [31:0]      sample_sel;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [QW-1:0]    fill;
   logic             single;
   logic             single_ok;
   logic             restart;

   assign wp_next     = advance(wp_ff);
   assign rp_next     = advance(rp_ff);
   assign full        = (wp_next == rp_ff);
   assign empty       = (wp_ff == rp_ff);
   assign count_match = (req_ff.word_count == cc_ff);
   assign skip_inc    = skip_ff + 16'd1;
   assign keep        = !(skip_inc < dec_ff);

   assign samples = {req_ff.sample_seven, req_ff.sample_six, req_ff.sample_five,
                     req_ff.sample_four, req_ff.sample_three, req_ff.sample_two,
                     req_ff.sample_one, req_ff.sample_zero};
   assign sample_sel = samples[3'(idx_ff)];

   assign wr_addr = ADDR_W'(wp_ff) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(idx_ff);
   assign rd_addr = ADDR_W'(rp_ff) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(idx_ff);

   assign sts.push_store = (req_ff.action == dfq_pkg::ACT_PUSH) && count_match
                           && keep && !full;
   assign sts.start_go   = (req_ff.action == dfq_pkg::ACT_START) && !sending_ff
                           && !empty && req_ff.link_accepts;
   assign sts.idx_last   = (idx_ff == IDX_W'(cc_ff - 4'd1));

   always_comb begin
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      sending_in  = sending_ff;
      skip_in     = skip_ff;
      drop_in     = drop_ff;
      err_in      = err_ff;
      cc_in       = cc_ff;
      dec_in      = dec_ff;
      idx_in      = idx_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in   = rsp_ok_ff;
      rsp_wv_in   = rsp_wv_ff;
      rsp_mem_in  = rsp_mem_ff;
      rsp_last_in = rsp_last_ff;
      single      = 1'b0;
      single_ok   = 1'b0;
      restart     = 1'b0;

      if (csr_write_en) begin
         case (csr_index)
            dfq_pkg::CSR_FRAME_WORDS: begin
               if (csr_wdata[3:0] != 4'd0 && csr_wdata[3:0] <= 4'(MAX_CHANNELS)) begin
                  cc_in   = csr_wdata[3:0];
                  restart = 1'b1;
               end
            end
            dfq_pkg::CSR_DECIMATION: begin
               if (csr_wdata != 16'd0) begin
                  dec_in  = csr_wdata;
                  restart = 1'b1;
               end
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end

      if (cmd.eval) begin
         idx_in = '0;
         case (req_ff.action)
            dfq_pkg::ACT_PUSH: begin
               if (!count_match) begin
                  single = 1'b1;
               end else if (!keep) begin
                  skip_in   = skip_inc;
                  single    = 1'b1;
                  single_ok = 1'b1;
               end else begin
                  skip_in = '0;
                  if (full) begin
                     drop_in = drop_ff + 32'd1;
                     single  = 1'b1;
                  end
               end
            end
            dfq_pkg::ACT_START: begin
               if (sts.start_go) sending_in = 1'b1;
               else single = 1'b1;
            end
            default: begin
               single = 1'b1;
               if (sending_ff) begin
                  if (req_ff.action == dfq_pkg::ACT_ERROR) err_in = err_ff + 32'd1;
                  rp_in      = rp_next;
                  sending_in = 1'b0;
                  single_ok  = 1'b1;
               end
            end
         endcase
      end

      if (cmd.write_word) idx_in = idx_ff + IDX_W'(1);

      if (cmd.commit_push) begin
         wp_in     = wp_next;
         single    = 1'b1;
         single_ok = 1'b1;
      end

      if (single) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = single_ok;
         rsp_wv_in    = 1'b0;
         rsp_mem_in   = 1'b0;
         rsp_last_in  = 1'b1;
      end

      if (cmd.read_word) begin
         idx_in       = idx_ff + IDX_W'(1);
         rsp_valid_in = 1'b1;
         rsp_ok_in    = 1'b1;
         rsp_wv_in    = 1'b1;
         rsp_mem_in   = 1'b1;
         rsp_last_in  = 1'b0;
      end

      if (cmd.send_tail) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = 1'b1;
         rsp_wv_in    = 1'b1;
         rsp_mem_in   = 1'b0;
         rsp_last_in  = 1'b1;
      end

      if (restart) begin
         wp_in      = '0;
         rp_in      = '0;
         sending_in = 1'b0;
         skip_in    = '0;
         drop_in    = '0;
         err_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         sending_ff   <= 1'b0;
         skip_ff      <= '0;
         drop_ff      <= '0;
         err_ff       <= '0;
         cc_ff        <= 4'd1;
         dec_ff       <= 16'd1;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         sending_ff   <= sending_in;
         skip_ff      <= skip_in;
         drop_ff      <= drop_in;
         err_ff       <= err_in;
         cc_ff        <= cc_in;
         dec_ff       <= dec_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_wv_ff   <= rsp_wv_in;
      rsp_mem_ff  <= rsp_mem_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.write_word) frame_store[wr_addr] <= sample_sel;
      if (cmd.read_word) mem_q_ff <= frame_store[rd_addr];
   end

   always_comb begin
      if (wp_ff >= rp_ff) fill = QW'(wp_ff) - QW'(rp_ff);
      else fill = QW'(wp_ff) + QW'(QUEUE_SLOTS) - QW'(rp_ff);
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.ok            = rsp_ok_ff;
   assign rsp_data.word_valid    = rsp_wv_ff;
   assign rsp_data.frame_word    = rsp_wv_ff ? (rsp_mem_ff ? mem_q_ff : dfq_pkg::TAIL_WORD)
                                             : 32'd0;
   assign rsp_data.last          = rsp_last_ff;
   assign rsp_data.queued        = fill[2:0];
   assign rsp_data.dropped_count = drop_ff;
   assign rsp_data.error_count   = err_ff;

   a_beat_while_sending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_wv_ff) |-> sending_ff)
      else $error("transmit beat without an open transmission");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.write_word |-> (wp_next != rp_ff))
      else $error("write into a queued slot");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.read_word |-> (!empty && sending_ff))
      else $error("read from an empty ring");

   a_commit_moves_wp: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_push && !csr_write_en) |=> (wp_ff == $past(wp_next)))
      else $error("write pointer did not advance on commit");

endmodule

// ===== test/decimated_frame_queue_framer_top_test.sv =====
// ============================================================================
// decimated_frame_queue_framer_top_test
// Self-checking bench for the decimated telemetry frame queue. A queue-fed
// driver issues push, start, done and error requests in random bursts. A
// behavioral ring model predicts every response beat, and a monitor checks
// each strobed beat field by field against the oldest prediction. Channel
// count and decimation are swept across phases, with out-of-range register
// writes mixed in.
// ============================================================================
module decimated_frame_queue_framer_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_SLOTS  = 8;
   localparam int MAX_CHANNELS = 8;
   localparam int STALL_LIMIT  = 3000;

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              start        = 1'b0;
   logic              busy;
   dfq_pkg::req_type  req_data     = '0;
   logic              rsp_valid;
   dfq_pkg::rsp_type  rsp_data;
   logic              csr_write_en = 1'b0;
   logic [0:0]        csr_index    = dfq_pkg::CSR_FRAME_WORDS;
   logic [15:0]       csr_wdata    = '0;

   decimated_frame_queue_framer_top #(
      .QUEUE_SLOTS  (QUEUE_SLOTS),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ring model
   logic [31:0] ring_words [QUEUE_SLOTS][MAX_CHANNELS];
   int          ring_wr;
   int          ring_rd;
   logic        link_busy;
   logic [15:0] skip_count;
   logic [31:0] drop_total;
   logic [31:0] error_total;
   logic [3:0]  chan_cfg = 4'd1;
   logic [15:0] keep_cfg = 16'd1;

   dfq_pkg::req_type req_backlog [$];
   dfq_pkg::rsp_type due_beats [$];

   int          mismatches;
   int          reqs_sent;
   int          beats_checked;
   int          frames_streamed;
   int          drops_seen;
   int          link_errors;
   int          csr_writes;
   int          quiet_cycles;

   int          burst_left;
   int          gap_left;
   int          bursts_done;
   logic        drain_hold;
   logic        hold_req;
   logic        present;

   function automatic void clear_ring();
      ring_wr     = 0;
      ring_rd     = 0;
      link_busy   = 1'b0;
      skip_count  = '0;
      drop_total  = '0;
      error_total = '0;
   endfunction

   function automatic void expect_beat(input logic ok, input logic valid,
                                       input logic [31:0] word, input logic last);
      dfq_pkg::rsp_type b;
      b.ok            = ok;
      b.word_valid    = valid;
      b.frame_word    = word;
      b.last          = last;
      b.queued        = 3'((ring_wr + QUEUE_SLOTS - ring_rd) % QUEUE_SLOTS);
      b.dropped_count = drop_total;
      b.error_count   = error_total;
      due_beats.push_back(b);
   endfunction

   function automatic void frame_queue_predict(input dfq_pkg::req_type r);
      logic [31:0] words [MAX_CHANNELS];
      int          nxt;
      words[0] = r.sample_zero;
      words[1] = r.sample_one;
      words[2] = r.sample_two;
      words[3] = r.sample_three;
      words[4] = r.sample_four;
      words[5] = r.sample_five;
      words[6] = r.sample_six;
      words[7] = r.sample_seven;
      case (r.action)
         dfq_pkg::ACT_PUSH: begin
            if (r.word_count != chan_cfg) begin
               expect_beat(1'b0, 1'b0, '0, 1'b1);
            end else begin
               skip_count = skip_count + 16'd1;
               if (skip_count < keep_cfg) begin
                  expect_beat(1'b1, 1'b0, '0, 1'b1);
               end else begin
                  skip_count = '0;
                  nxt = (ring_wr + 1) % QUEUE_SLOTS;
                  if (nxt == ring_rd) begin
                     drop_total = drop_total + 32'd1;
                     drops_seen++;
                     expect_beat(1'b0, 1'b0, '0, 1'b1);
                  end else begin
                     for (int i = 0; i < chan_cfg; i++) ring_words[ring_wr][i] = words[i];
                     ring_wr = nxt;
                     expect_beat(1'b1, 1'b0, '0, 1'b1);
                  end
               end
            end
         end
         dfq_pkg::ACT_START: begin
            if (link_busy || ring_rd == ring_wr || !r.link_accepts) begin
               expect_beat(1'b0, 1'b0, '0, 1'b1);
            end else begin
               link_busy = 1'b1;
               frames_streamed++;
               for (int i = 0; i < chan_cfg; i++)
                  expect_beat(1'b1, 1'b1, ring_words[ring_rd][i], 1'b0);
               expect_beat(1'b1, 1'b1, dfq_pkg::TAIL_WORD, 1'b1);
            end
         end
         default: begin
            if (!link_busy) begin
               expect_beat(1'b0, 1'b0, '0, 1'b1);
            end else begin
               if (r.action == dfq_pkg::ACT_ERROR) begin
                  error_total = error_total + 32'd1;
                  link_errors++;
               end
               ring_rd   = (ring_rd + 1) % QUEUE_SLOTS;
               link_busy = 1'b0;
               expect_beat(1'b1, 1'b0, '0, 1'b1);
            end
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic dfq_pkg::req_type random_item(input logic [3:0] ch);
      dfq_pkg::req_type r;
      int               pick;
      r.sample_zero  = pick_word();
      r.sample_one   = pick_word();
      r.sample_two   = pick_word();
      r.sample_three = pick_word();
      r.sample_four  = pick_word();
      r.sample_five  = pick_word();
      r.sample_six   = pick_word();
      r.sample_seven = pick_word();
      r.word_count   = ch;
      r.link_accepts = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.action = dfq_pkg::ACT_PUSH;
      end else if (pick < 52) begin
         r.action = dfq_pkg::ACT_PUSH;
         do r.word_count = 4'($urandom_range(0, 8)); while (r.word_count == ch);
      end else if (pick < 75) begin
         r.action       = dfq_pkg::ACT_START;
         r.link_accepts = ($urandom_range(0, 7) != 0);
      end else if (pick < 88) begin
         r.action = dfq_pkg::ACT_DONE;
      end else if (pick < 96) begin
         r.action = dfq_pkg::ACT_ERROR;
      end else begin
         r.action       = 2'($urandom);
         r.word_count   = 4'($urandom_range(0, 8));
         r.link_accepts = 1'($urandom);
      end
      return r;
   endfunction

   function automatic dfq_pkg::req_type make_req(input logic [1:0] act,
                                                 input logic [3:0] wc,
                                                 input logic [31:0] s0,
                                                 input logic acc);
      dfq_pkg::req_type r;
      r              = random_item(4'd8);
      r.action       = act;
      r.word_count   = wc;
      r.sample_zero  = s0;
      r.link_accepts = acc;
      return r;
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (req_backlog.size() != 0 || start || busy || due_beats.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      csr_writes++;
      if (idx == dfq_pkg::CSR_FRAME_WORDS) begin
         if (val[3:0] >= 4'd1 && val[3:0] <= 4'(MAX_CHANNELS)) begin
            chan_cfg = val[3:0];
            clear_ring();
         end
      end else if (val != 16'd0) begin
         keep_cfg = val;
         clear_ring();
      end
   endtask

   task automatic run_phase(input logic [15:0] chan_word, input logic [15:0] keep_word,
                            input int beats);
      write_csr(dfq_pkg::CSR_FRAME_WORDS, chan_word);
      write_csr(dfq_pkg::CSR_DECIMATION, keep_word);
      for (int k = 0; k < beats; k++) req_backlog.push_back(random_item(chan_cfg));
      wait_idle();
   endtask

   // driver: hold a beat while busy, otherwise advance through bursts and gaps
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
         drain_hold = 1'b0;
      end else begin
         hold_req = start && busy;
         if (start && !busy) begin
            frame_queue_predict(req_data);
            reqs_sent++;
         end
         if (!hold_req) begin
            present = 1'b0;
            if (drain_hold) begin
               if (due_beats.size() == 0) drain_hold = 1'b0;
            end else if (gap_left != 0) begin
               gap_left--;
            end else if (req_backlog.size() != 0) begin
               present = 1'b1;
               req_data <= req_backlog.pop_front();
               if (burst_left != 0) begin
                  burst_left--;
               end else begin
                  bursts_done++;
                  burst_left = $urandom_range(0, 11);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                  drain_hold = ($urandom_range(0, 19) == 0) || (bursts_done % 4 == 3);
               end
            end
            start <= present;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (due_beats.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected response beat: word %h last %b", rsp_data.frame_word,
                        rsp_data.last);
            mismatches++;
         end else begin
            automatic dfq_pkg::rsp_type want = due_beats.pop_front();
            beats_checked++;
            if (rsp_data.ok !== want.ok || rsp_data.word_valid !== want.word_valid ||
                rsp_data.frame_word !== want.frame_word || rsp_data.last !== want.last ||
                rsp_data.queued !== want.queued ||
                rsp_data.dropped_count !== want.dropped_count ||
                rsp_data.error_count !== want.error_count) begin
               if (mismatches < 10) begin
                  $display("beat %0d mismatch: ok/valid/word/last/queued/drop/err", beats_checked);
                  $display("  expected %b %b %h %b %0d %h %h", want.ok, want.word_valid,
                           want.frame_word, want.last, want.queued, want.dropped_count,
                           want.error_count);
                  $display("  actual   %b %b %h %b %0d %h %h", rsp_data.ok, rsp_data.word_valid,
                           rsp_data.frame_word, rsp_data.last, rsp_data.queued,
                           rsp_data.dropped_count, rsp_data.error_count);
               end
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_en) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      clear_ring();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      req_backlog.push_back(make_req(dfq_pkg::ACT_DONE, 4'd1, $urandom, 1'b1));
      req_backlog.push_back(make_req(dfq_pkg::ACT_ERROR, 4'd1, $urandom, 1'b1));
      req_backlog.push_back(make_req(dfq_pkg::ACT_START, 4'd1, $urandom, 1'b1));
      req_backlog.push_back(make_req(dfq_pkg::ACT_PUSH, 4'd0, $urandom, 1'b1));
      req_backlog.push_back(make_req(dfq_pkg::ACT_PUSH, 4'd8, $urandom, 1'b1));
      req_backlog.push_back(make_req(dfq_pkg::ACT_PUSH, 4'd1, 32'hFFFF_FFFF, 1'b1));
      req_backlog.push_back(make_req(dfq_pkg::ACT_PUSH, 4'd1, 32'h0000_0000, 1'b1));
      req_backlog.push_back(make_req(dfq_pkg::ACT_START, 4'd1, $urandom, 1'b0));
      req_backlog.push_back(make_req(dfq_pkg::ACT_START, 4'd1, $urandom, 1'b1));
      req_backlog.push_back(make_req(dfq_pkg::ACT_START, 4'd1, $urandom, 1'b1));
      req_backlog.push_back(make_req(dfq_pkg::ACT_DONE, 4'd1, $urandom, 1'b1));
      req_backlog.push_back(make_req(dfq_pkg::ACT_START, 4'd1, $urandom, 1'b1));
      req_backlog.push_back(make_req(dfq_pkg::ACT_ERROR, 4'd1, $urandom, 1'b1));
      for (int k = 0; k < 9; k++)
         req_backlog.push_back(make_req(dfq_pkg::ACT_PUSH, 4'd1, $urandom, 1'b1));
      wait_idle();

      // out-of-range writes leave the full ring and settings alone
      write_csr(dfq_pkg::CSR_FRAME_WORDS, 16'h0000);
      write_csr(dfq_pkg::CSR_FRAME_WORDS, 16'h0009);
      write_csr(dfq_pkg::CSR_FRAME_WORDS, 16'h00F0);
      write_csr(dfq_pkg::CSR_DECIMATION, 16'h0000);
      req_backlog.push_back(make_req(dfq_pkg::ACT_START, 4'd1, $urandom, 1'b1));
      req_backlog.push_back(make_req(dfq_pkg::ACT_DONE, 4'd1, $urandom, 1'b1));
      wait_idle();

      run_phase(16'hFFF8, 16'd1, 40);
      run_phase(16'd3, 16'd2, 40);
      run_phase(16'd1, 16'd1, 30);
      run_phase(16'h5A75, 16'd3, 30);
      run_phase(16'd8, 16'hFFFF, 14);
      run_phase(16'd2, 16'd1, 30);

      $display("covered %0d requests, %0d response beats, %0d frames streamed",
               reqs_sent, beats_checked, frames_streamed);
      $display("  %0d ring-full drops, %0d link errors, %0d register writes, %0d mismatches",
               drops_seen, link_errors, csr_writes, mismatches);
      if (mismatches == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dfq_pkg.sv
hw/rtl/dfq_ctrl.sv
hw/rtl/dfq_datapath.sv
hw/rtl/decimated_frame_queue_framer_top.sv
test/decimated_frame_queue_framer_top_test.sv
